// File: hw/rtl/i2a_pkg.sv
// i2a_pkg: shared constants, codes and helpers for the integer to ASCII formatter.
// No dependencies; imported by all i2a modules and the top level.
package i2a_pkg;

  localparam int DEC_DIGITS = 10;
  localparam int MAG_W      = 32;
  localparam int BCD_W      = DEC_DIGITS * 4;
  // digit counter covers up to 16 hex digits
  localparam int CNT_W      = 5;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       pfx_t;

  localparam pfx_t PFX_NONE  = 2'd0;
  localparam pfx_t PFX_MINUS = 2'd1;
  localparam pfx_t PFX_ZERO  = 2'd2;  // "0" of "0x"
  localparam pfx_t PFX_X     = 2'd3;  // "x" of "0x"

  localparam logic [1:0] CMD_DEC   = 2'd0;
  localparam logic [1:0] CMD_HEX32 = 2'd1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // emitter load control
  typedef struct packed {
    logic load;
    cnt_t cnt;   // digits held, top aligned
    cnt_t min;   // digits always written
    pfx_t pfx;
  } emit_ctl_t;

  function automatic logic [7:0] nib_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return CH_UPPER + {4'd0, nib} - 8'd10;
  endfunction

endpackage

// File: hw/rtl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: formats one number as decimal or hex ASCII, one char per strobe.
// Depends on i2a_pkg, i2a_bcd_conv, i2a_char_emit.
// Decimal runs the bit-serial conversion, a load, then the digit slots, led by a sign char
// when negative; hex sends the 0x prefix, then 8 or HEX_DIGITS nibble slots. Busy drops with the
// last char, and a new number is accepted only while idle; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns to idle and clears all strobes.
module integer_to_ascii_formatter
  import i2a_pkg::*;
#(
  parameter int HEX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_value,
  input  logic [3:0]  in_min_width,
  output logic        out_strobe,
  output logic [7:0]  out_char_out,
  output logic        out_last
);

  localparam int HEX_W = HEX_DIGITS * 4;
  localparam int SR_W  = (HEX_W > BCD_W) ? HEX_W : BCD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             neg_r;
  cnt_t             min_r;
  logic             accept, is_dec, is_hex32;
  logic             in_neg;
  logic [MAG_W-1:0] mag;
  cnt_t             dec_min;
  logic             conv_done, emit_done;
  logic [BCD_W-1:0] bcd;
  emit_ctl_t        ctl;
  logic [SR_W-1:0]  digits;

  assign accept   = start && (state_r == S_IDLE);
  assign is_dec   = (in_cmd == CMD_DEC);
  assign is_hex32 = (in_cmd == CMD_HEX32);
  assign in_neg   = in_value[MAG_W-1];
  assign mag      = in_neg ? (MAG_W'(0) - in_value[MAG_W-1:0]) : in_value[MAG_W-1:0];

  always_comb begin
    if (in_min_width > 4'(DEC_DIGITS)) begin
      dec_min = cnt_t'(DEC_DIGITS);
    end else if (in_min_width == 4'd0) begin
      dec_min = cnt_t'(1);
    end else begin
      dec_min = cnt_t'(in_min_width);
    end
  end

  always_comb begin
    ctl    = '0;
    digits = '0;
    if (state_r == S_CONV) begin
      ctl.load = conv_done;
      ctl.cnt  = cnt_t'(DEC_DIGITS);
      ctl.min  = min_r;
      ctl.pfx  = neg_r ? PFX_MINUS : PFX_NONE;
      digits   = SR_W'(bcd) << (SR_W - BCD_W);
    end else if (accept && !is_dec) begin
      ctl.load = 1'b1;
      ctl.pfx  = PFX_ZERO;
      if (is_hex32) begin
        ctl.cnt = cnt_t'(8);
        ctl.min = cnt_t'(1);
        digits  = SR_W'(in_value[31:0]) << (SR_W - 32);
      end else begin
        ctl.cnt = cnt_t'(HEX_DIGITS);
        ctl.min = cnt_t'(HEX_DIGITS);
        digits  = SR_W'(in_value[HEX_W-1:0]) << (SR_W - HEX_W);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = is_dec ? S_CONV : S_EMIT;
      S_CONV: if (conv_done) state_nxt = S_EMIT;
      S_EMIT: if (emit_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_neg;
      min_r <= dec_min;
    end
  end

  i2a_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept && is_dec),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  i2a_char_emit #(
    .SR_W (SR_W)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .digits   (digits),
    .done     (emit_done),
    .strobe   (out_strobe),
    .char_out (out_char_out),
    .last     (out_last)
  );

  assign busy = (state_r != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("char strobed right after last");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("non-final char while idle");

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe && $past(busy))
    else $error("last flag without active number");

endmodule

// File: hw/rtl/i2a_bcd_conv.sv
// i2a_bcd_conv: bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on i2a_pkg.
module i2a_bcd_conv
  import i2a_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [MAG_W-1:0] mag,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  localparam int SC_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r, adj, bcd_nxt;
  logic [SC_W-1:0]  cnt_r;
  logic             done_r;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
    bcd_nxt = {adj[BCD_W-2:0], bin_r[MAG_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == SC_W'(1)) && !load;
      if (load) begin
        cnt_r <= SC_W'(MAG_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - SC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin_r <= mag;
      bcd_r <= '0;
    end else if (cnt_r != '0) begin
      bin_r <= {bin_r[MAG_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// File: hw/rtl/i2a_char_emit.sv
// i2a_char_emit: prefix and digit emitter; after any prefix chars, shifts out one nibble per cycle,
// skipping leading zeros down to a minimum count. Depends on i2a_pkg.
module i2a_char_emit
  import i2a_pkg::*;
#(
  parameter int SR_W = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  emit_ctl_t       ctl,
  input  logic [SR_W-1:0] digits,
  output logic            done,
  output logic            strobe,
  output logic [7:0]      char_out,
  output logic            last
);

  logic [SR_W-1:0] sr_r;
  cnt_t            cnt_r, min_r;
  pfx_t            pfx_r;
  logic            started_r, active_r;
  logic            strobe_r, last_r;
  logic [7:0]      char_r;
  logic [3:0]      top;
  logic            skip;

  assign top  = sr_r[SR_W-1 -: 4];
  assign skip = !started_r && (cnt_r > min_r) && (top == 4'd0);
  assign done = active_r && (pfx_r == PFX_NONE) && !skip && (cnt_r == cnt_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      started_r <= 1'b0;
      pfx_r     <= PFX_NONE;
      strobe_r  <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      if (ctl.load) begin
        active_r  <= 1'b1;
        started_r <= 1'b0;
        pfx_r     <= ctl.pfx;
      end else if (active_r) begin
        unique case (pfx_r) inside
          PFX_MINUS, PFX_X: begin
            strobe_r <= 1'b1;
            pfx_r    <= PFX_NONE;
          end
          PFX_ZERO: begin
            strobe_r <= 1'b1;
            pfx_r    <= PFX_X;
          end
          default: begin
            if (!skip) begin
              strobe_r  <= 1'b1;
              started_r <= 1'b1;
              last_r    <= (cnt_r == cnt_t'(1));
              if (cnt_r == cnt_t'(1)) active_r <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sr_r  <= digits;
      cnt_r <= ctl.cnt;
      min_r <= ctl.min;
    end else if (active_r && pfx_r == PFX_NONE) begin
      sr_r  <= sr_r << 4;
      cnt_r <= cnt_r - cnt_t'(1);
    end
    case (pfx_r)
      PFX_MINUS: char_r <= CH_MINUS;
      PFX_ZERO:  char_r <= CH_ZERO;
      PFX_X:     char_r <= CH_X;
      default:   char_r <= nib_char(top);
    endcase
  end

  assign strobe   = strobe_r;
  assign char_out = char_r;
  assign last     = last_r;

endmodule
